>>> hdl/calendar_month_grid_generator_defines.svh
// ----------------------------------------------------------------------------
// calendar month grid generator assertion macros
// shared assertion forms, clocked on clk and quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef CALENDAR_MONTH_GRID_GENERATOR_DEFINES_SVH
`define CALENDAR_MONTH_GRID_GENERATOR_DEFINES_SVH

// property checked at every edge outside reset
`define CMGG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define CMGG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/cmgg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmgg_pkg
// widths, constants, job type and calendar helpers for the month grid
// ----------------------------------------------------------------------------
package cmgg_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int OFFSET_W = 12;

	localparam int GRID_ROWS  = 6;
	localparam int GRID_COLS  = 7;
	localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
	localparam int CELL_W     = $clog2(GRID_CELLS);

	localparam int MONTHS     = 12;
	localparam int TOTAL_W    = 17;
	localparam int TOTAL_MIN  = MONTHS;
	localparam int TOTAL_MAX  = 9999 * MONTHS + MONTHS - 1;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

	// reciprocals for constant division
	localparam logic [15:0] RECIP_3   = 16'd43691;  // >> 17
	localparam logic [12:0] RECIP_100 = 13'd5243;   // >> 19
	localparam logic [17:0] RECIP_7   = 18'd149797; // >> 20

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct packed {
		date_t              start;
		logic               leap;
		logic [YEAR_W-1:0]  shown_year;
		logic [MONTH_W-1:0] shown_month;
		date_t              today;
	} job_t;

	function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] d;
		unique case (m)
			4'd1:                      d = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
			default:                   d = 5'd31;
		endcase
		return d;
	endfunction

	// day of year counted from march 1 for the first of month m
	function automatic logic [8:0] march_doy(input logic [MONTH_W-1:0] m);
		logic [8:0] d;
		unique case (m)
			4'd0:    d = 9'd306;
			4'd1:    d = 9'd337;
			4'd2:    d = 9'd0;
			4'd3:    d = 9'd31;
			4'd4:    d = 9'd61;
			4'd5:    d = 9'd92;
			4'd6:    d = 9'd122;
			4'd7:    d = 9'd153;
			4'd8:    d = 9'd184;
			4'd9:    d = 9'd214;
			4'd10:   d = 9'd245;
			default: d = 9'd275;
		endcase
		return d;
	endfunction

endpackage

>>> hdl/cmgg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmgg_if
// request and grid cell channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface cmgg_in_if;
	logic                               valid;
	logic                               ready;
	logic [cmgg_pkg::YEAR_W-1:0]        base_year;
	logic [cmgg_pkg::MONTH_W-1:0]       base_month;
	logic signed [cmgg_pkg::OFFSET_W-1:0] mon_shift;
	logic [cmgg_pkg::YEAR_W-1:0]        today_year;
	logic [cmgg_pkg::MONTH_W-1:0]       today_month;
	logic [cmgg_pkg::DAY_W-1:0]         today_day;

	modport source (output valid, base_year, base_month, mon_shift, today_year,
		today_month, today_day, input ready);
	modport sink (input valid, base_year, base_month, mon_shift, today_year,
		today_month, today_day, output ready);
endinterface

interface cmgg_out_if;
	logic                         valid;
	logic                         ready;
	logic [cmgg_pkg::YEAR_W-1:0]  cell_year;
	logic [cmgg_pkg::MONTH_W-1:0] cell_mon;
	logic [cmgg_pkg::DAY_W-1:0]   cell_day;
	logic                         in_shown;
	logic                         today_hit;
	logic [cmgg_pkg::YEAR_W-1:0]  shown_year;
	logic [cmgg_pkg::MONTH_W-1:0] shown_month;
	logic                         last_cell;

	modport source (output valid, cell_year, cell_mon, cell_day, in_shown, today_hit,
		shown_year, shown_month, last_cell, input ready);
	modport sink (input valid, cell_year, cell_mon, cell_day, in_shown, today_hit,
		shown_year, shown_month, last_cell, output ready);
endinterface

>>> hdl/calendar_month_grid_generator.sv
// path: a request passes front stages s1 to s7, the job queue, the walker start registers and the cell output registers
// throughput: 42 cells per request, one per cycle while grid.ready is high
// the cell walker sets that rate, the date pipeline and job queue run ahead of it
// reset: arst_n clears all valid bits, queue pointers and the walker; no clearing pass
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_month_grid_generator
// monday-first gregorian month grid: shifts the month, finds the weekday of the
// first and streams the 6 by 7 grid of dates
// ----------------------------------------------------------------------------
`include "calendar_month_grid_generator_defines.svh"

module calendar_month_grid_generator (
	input  logic       clk,
	input  logic       arst_n,
	cmgg_in_if.sink    req,
	cmgg_out_if.source grid
);

	logic           f_valid, f_ready;
	cmgg_pkg::job_t f_job;
	logic           b_valid, b_ready;
	cmgg_pkg::job_t b_job;

	cmgg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	cmgg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_job   (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_job    (b_job)
	);

	cmgg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.grid      (grid)
	);

	// consecutive cells of one grid are consecutive dates
	`CMGG_ASSERT_NEXT(a_day_steps, grid.valid && grid.ready && !grid.last_cell, grid.valid && ((grid.cell_day == $past(grid.cell_day) + 5'd1) || (grid.cell_day == 5'd1)), "grid cells are not consecutive days")

	// the shown month does not change inside a grid
	`CMGG_ASSERT_NEXT(a_shown_stable, grid.valid && grid.ready && !grid.last_cell, $stable(grid.shown_year) && $stable(grid.shown_month), "shown month changed within a grid")

	// a stalled cell holds until it is taken
	`CMGG_ASSERT_NEXT(a_cell_held, grid.valid && !grid.ready, grid.valid && $stable(grid.cell_day) && $stable(grid.last_cell), "stalled cell changed")

endmodule

>>> hdl/cmgg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmgg_front
// month shift, saturation and weekday pipeline producing the grid start date
// ----------------------------------------------------------------------------
module cmgg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	cmgg_in_if.sink              req,
	output logic                 job_valid,
	input  logic                 job_ready,
	output cmgg_pkg::job_t       job
);

	localparam int YW = cmgg_pkg::YEAR_W;
	localparam int MW = cmgg_pkg::MONTH_W;
	localparam int DW = cmgg_pkg::DAY_W;
	localparam int TW = cmgg_pkg::TOTAL_W;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	cmgg_pkg::date_t today_s1, today_s2, today_s3, today_s4, today_s5, today_s6, today_s7;

	logic [YW-1:0]                  by_s1;
	logic [MW-1:0]                  bm_s1;
	logic [cmgg_pkg::OFFSET_W-1:0]  off_s1;
	logic [TW-1:0]                  total_s2, total_s3;
	logic [YW-1:0]                  q12_s3;
	logic [YW-1:0]                  sy_s4, sy_s5, sy_s6, sy_s7;
	logic [MW-1:0]                  sm_s4, sm_s5, sm_s6, sm_s7;
	logic [YW-1:0]                  yy_s5;
	logic [6:0]                     cy_s5, cs_s5;
	logic [YW-1:0]                  wsum_s6, wsum_s7;
	logic                           leap_s6, leap_s7;
	logic [10:0]                    q7_s7;

	// stage 1 -> 2: month count with saturation
	logic signed [19:0] tot_raw;
	logic [19:0]        base_cnt;
	logic [TW-1:0]      tot_sat;

	// stage 2 -> 3, 3 -> 4, 4 -> 5, 5 -> 6, 6 -> 7
	logic [30:0]        p3;
	logic [TW-1:0]      rem4;
	logic [YW-1:0]      sy4;
	logic [MW-1:0]      sm4;
	logic [YW-1:0]      yy4;
	logic [26:0]        py5, ps5;
	logic [YW-1:0]      cs100;
	logic [YW-1:0]      wsum6;
	logic [31:0]        p7;

	// final combinational step into the queue
	logic [YW-1:0]      col_full;
	logic [2:0]         col;
	logic [MW-1:0]      prev_m;
	logic [YW-1:0]      prev_y;
	logic [DW-1:0]      prev_dim;

	assign adv       = !v_s7 || job_ready;
	assign req.ready = adv;

	always_comb begin
		base_cnt = ({6'd0, by_s1} << 3) + ({6'd0, by_s1} << 2) + {16'd0, bm_s1};
		tot_raw  = $signed(base_cnt) + $signed({{8{off_s1[cmgg_pkg::OFFSET_W-1]}}, off_s1});
		if (tot_raw < 20'(cmgg_pkg::TOTAL_MIN)) begin
			tot_sat = TW'(cmgg_pkg::TOTAL_MIN);
		end else if (tot_raw > 20'(cmgg_pkg::TOTAL_MAX)) begin
			tot_sat = TW'(cmgg_pkg::TOTAL_MAX);
		end else begin
			tot_sat = tot_raw[TW-1:0];
		end
	end

	// total / 12 as (total / 4) / 3
	assign p3 = 31'(total_s2[TW-1:2]) * 31'(cmgg_pkg::RECIP_3);

	always_comb begin
		rem4 = total_s3 - ((TW'(q12_s3) << 3) + (TW'(q12_s3) << 2));
		if (rem4 >= TW'(cmgg_pkg::MONTHS)) begin
			sy4 = q12_s3 + 1'b1;
			sm4 = MW'(rem4 - TW'(cmgg_pkg::MONTHS));
		end else begin
			sy4 = q12_s3;
			sm4 = MW'(rem4);
		end
	end

	// march-based year: jan and feb belong to the year before
	assign yy4 = (sm_s4 <= cmgg_pkg::MONTH_FEB) ? sy_s4 - 1'b1 : sy_s4;
	assign py5 = 27'(yy4) * 27'(cmgg_pkg::RECIP_100);
	assign ps5 = 27'(sy_s4) * 27'(cmgg_pkg::RECIP_100);

	assign cs100 = (YW'(cs_s5) << 6) + (YW'(cs_s5) << 5) + (YW'(cs_s5) << 2);
	assign wsum6 = yy_s5 + (yy_s5 >> 2) - YW'(cy_s5) + YW'(cy_s5 >> 2)
		+ YW'(cmgg_pkg::march_doy(sm_s5)) + YW'(2);

	assign p7 = 32'(wsum_s6) * 32'(cmgg_pkg::RECIP_7);

	always_comb begin
		col_full = wsum_s7 - ((YW'(q7_s7) << 3) - YW'(q7_s7));
		col      = col_full[2:0];
		if (sm_s7 == cmgg_pkg::MONTH_JAN) begin
			prev_m = cmgg_pkg::MONTH_DEC;
			prev_y = sy_s7 - 1'b1;
		end else begin
			prev_m = sm_s7 - 1'b1;
			prev_y = sy_s7;
		end
		prev_dim = cmgg_pkg::days_in_month(prev_m, leap_s7);

		job.leap        = leap_s7;
		job.shown_year  = sy_s7;
		job.shown_month = sm_s7;
		job.today       = today_s7;
		if (col == 3'd0) begin
			job.start.year  = sy_s7;
			job.start.month = sm_s7;
			job.start.day   = DW'(1);
		end else begin
			job.start.year  = prev_y;
			job.start.month = prev_m;
			job.start.day   = prev_dim - DW'(col) + DW'(1);
		end
	end

	assign job_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			by_s1          <= req.base_year;
			bm_s1          <= req.base_month;
			off_s1         <= req.mon_shift;
			today_s1.year  <= req.today_year;
			today_s1.month <= req.today_month;
			today_s1.day   <= req.today_day;

			total_s2 <= tot_sat;
			today_s2 <= today_s1;

			total_s3 <= total_s2;
			q12_s3   <= p3[30:17];
			today_s3 <= today_s2;

			sy_s4    <= sy4;
			sm_s4    <= sm4;
			today_s4 <= today_s3;

			yy_s5    <= yy4;
			cy_s5    <= py5[25:19];
			cs_s5    <= ps5[25:19];
			sy_s5    <= sy_s4;
			sm_s5    <= sm_s4;
			today_s5 <= today_s4;

			wsum_s6  <= wsum6;
			leap_s6  <= (sy_s5[1:0] == 2'd0) && ((sy_s5 != cs100) || (cs_s5[1:0] == 2'd0));
			sy_s6    <= sy_s5;
			sm_s6    <= sm_s5;
			today_s6 <= today_s5;

			wsum_s7  <= wsum_s6;
			q7_s7    <= p7[30:20];
			leap_s7  <= leap_s6;
			sy_s7    <= sy_s6;
			sm_s7    <= sm_s6;
			today_s7 <= today_s6;
		end
	end

endmodule

>>> hdl/cmgg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmgg_queue
// short job queue between the date pipeline and the cell walker
// ----------------------------------------------------------------------------
module cmgg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  cmgg_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output cmgg_pkg::job_t pop_job
);

	localparam int PW = cmgg_pkg::QPTR_W;
	localparam int CW = cmgg_pkg::QCNT_W;

	cmgg_pkg::job_t entries_q [cmgg_pkg::QDEPTH];
	logic [PW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign push_ready = count_q != CW'(cmgg_pkg::QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = entries_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(cmgg_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(cmgg_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wptr_q] <= push_job;
		end
	end

endmodule

>>> hdl/cmgg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmgg_back
// cell walker: steps day by day from the grid start and emits 42 cells
// ----------------------------------------------------------------------------
module cmgg_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  cmgg_pkg::job_t job,
	cmgg_out_if.source     grid
);

	localparam int NW = cmgg_pkg::CELL_W;

	logic            busy_q;
	logic [NW-1:0]   cnt_q;
	cmgg_pkg::date_t cur_q, cur_next;
	cmgg_pkg::job_t  job_q;
	logic            out_valid_q;

	logic                          advance, last, pop;
	logic [cmgg_pkg::DAY_W-1:0]    dim;

	logic [cmgg_pkg::YEAR_W-1:0]   cell_year_q;
	logic [cmgg_pkg::MONTH_W-1:0]  cell_mon_q;
	logic [cmgg_pkg::DAY_W-1:0]    cell_day_q;
	logic                          in_shown_q, today_hit_q, last_cell_q;
	logic [cmgg_pkg::YEAR_W-1:0]   shown_year_q;
	logic [cmgg_pkg::MONTH_W-1:0]  shown_month_q;

	assign advance   = busy_q && (!out_valid_q || grid.ready);
	assign last      = cnt_q == NW'(cmgg_pkg::GRID_CELLS - 1);
	// next job loads on the same edge that sends the last cell
	assign job_ready = !busy_q || (advance && last);
	assign pop       = job_valid && job_ready;

	// feb only appears in the shown year, so one leap flag serves the grid
	assign dim = cmgg_pkg::days_in_month(cur_q.month, job_q.leap);

	always_comb begin
		cur_next = cur_q;
		if (cur_q.day == dim) begin
			cur_next.day = cmgg_pkg::DAY_W'(1);
			if (cur_q.month == cmgg_pkg::MONTH_DEC) begin
				cur_next.month = cmgg_pkg::MONTH_JAN;
				cur_next.year  = cur_q.year + 1'b1;
			end else begin
				cur_next.month = cur_q.month + 1'b1;
			end
		end else begin
			cur_next.day = cur_q.day + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (advance && last) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (grid.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= job.start;
			job_q <= job;
		end else if (advance) begin
			cur_q <= cur_next;
		end
		if (advance) begin
			cell_year_q   <= cur_q.year;
			cell_mon_q    <= cur_q.month;
			cell_day_q    <= cur_q.day;
			in_shown_q    <= (cur_q.year == job_q.shown_year)
				&& (cur_q.month == job_q.shown_month);
			today_hit_q   <= (cur_q.year == job_q.today.year)
				&& (cur_q.month == job_q.today.month) && (cur_q.day == job_q.today.day);
			shown_year_q  <= job_q.shown_year;
			shown_month_q <= job_q.shown_month;
			last_cell_q   <= last;
		end
	end

	assign grid.valid       = out_valid_q;
	assign grid.cell_year   = cell_year_q;
	assign grid.cell_mon    = cell_mon_q;
	assign grid.cell_day    = cell_day_q;
	assign grid.in_shown    = in_shown_q;
	assign grid.today_hit   = today_hit_q;
	assign grid.shown_year  = shown_year_q;
	assign grid.shown_month = shown_month_q;
	assign grid.last_cell   = last_cell_q;

endmodule
